@@ rtl/eigen_pairs_2x2_assert.svh @@
// Assertion macros used by the eigen_pairs_2x2 checker.
`ifndef EIGEN_PAIRS_2X2_ASSERT_SVH
`define EIGEN_PAIRS_2X2_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EIG2_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EIG2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/eig2_pkg.sv @@
// Types, widths and the square-root step function of the 2x2 eigen solver.
`default_nettype none

package eig2_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 16;
  localparam int RES_W     = 19;
  localparam int T_W       = DATA_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DET_W     = PROD_W + 1;
  localparam int TT_W      = 2 * T_W;
  localparam int DISC_W    = 36;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_STAGES = 3;
  localparam int SQ_STEPS  = ROOT_W / SQ_STAGES;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [RES_W-1:0]  val_t;
  typedef logic signed [T_W-1:0]    tr_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic signed [TT_W-1:0]   tt_t;
  typedef logic signed [DISC_W-1:0] disc_t;

  localparam val_t ONE_V = val_t'(2 ** (FRAC_BITS + 1));

  typedef struct packed {
    data_t a00;
    data_t a01;
    data_t a10;
    data_t a11;
  } mat_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    mat_t m;
    tr_t  t;
    logic neg;
    sq_t  sq;
  } sqs_t;

  // Several bit pairs of the restoring square root, consumed from the top of rad.
  function automatic sqs_t sqrt_run(sqs_t x);
    sqs_t             c;
    logic [REM_W-1:0] rsh;
    logic [REM_W-1:0] trial;
    c = x;
    for (int j = 0; j < SQ_STEPS; j++) begin
      rsh   = {c.sq.rem[REM_W-3:0], c.sq.rad[RAD_W-1 -: 2]};
      trial = REM_W'({c.sq.root, 2'b01});
      c.sq.rad = c.sq.rad << 2;
      if (rsh >= trial) begin
        c.sq.rem  = rsh - trial;
        c.sq.root = {c.sq.root[ROOT_W-2:0], 1'b1};
      end else begin
        c.sq.rem  = rsh;
        c.sq.root = {c.sq.root[ROOT_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/eig2_in_if.sv @@
// Matrix input channel with valid/ready handshake.
`default_nettype none

interface eig2_in_if;
  import eig2_pkg::*;

  logic  valid;
  logic  ready;
  data_t a00;
  data_t a01;
  data_t a10;
  data_t a11;

  modport source (output valid, output a00, output a01, output a10, output a11,
                  input ready);
  modport sink (input valid, input a00, input a01, input a10, input a11,
                output ready);
endinterface

`default_nettype wire

@@ rtl/eig2_out_if.sv @@
// Eigenpair result channel with valid/ready handshake.
`default_nettype none

interface eig2_out_if;
  import eig2_pkg::*;

  logic valid;
  logic ready;
  logic last;
  val_t lambda_re;
  val_t lambda_im;
  val_t vec_x_re;
  val_t vec_x_im;
  val_t vec_y_re;
  val_t vec_y_im;

  modport source (output valid, output last, output lambda_re, output lambda_im,
                  output vec_x_re, output vec_x_im, output vec_y_re, output vec_y_im,
                  input ready);
  modport sink (input valid, input last, input lambda_re, input lambda_im,
                input vec_x_re, input vec_x_im, input vec_y_re, input vec_y_im,
                output ready);
endinterface

`default_nettype wire

@@ rtl/eigen_pairs_2x2.sv @@
// Top level of the pipelined 2x2 eigenvalue and eigenvector solver.
// The first result beat passes through s0, s1, s2, the square-root stages and the output register.
// The second beat of the same matrix follows in the cycle after the first beat is taken.
// New matrices are accepted while earlier ones are still in flight; the two result beats limit sustained intake.
// Reset is asynchronous and active low; it empties every pipeline stage.
`default_nettype none

module eigen_pairs_2x2 (
  input  logic            clk_i,
  input  logic            rst_ni,
  eig2_in_if.sink         in_i,
  eig2_out_if.source      out_o
);
  import eig2_pkg::*;

  logic  s0_v_q, s1_v_q, s2_v_q, ov_q, phase_q;
  logic  ld0, ld1, ld2, ld_out;
  logic  [SQ_STAGES-1:0] sq_v_q, sq_v_src, ld_sq;

  mat_t  s0_m_q, s1_m_q;
  tr_t   s0_t_q, s1_t_q;
  prod_t s0_p0_q, s0_p1_q;
  tt_t   s0_tt_q, s1_tt_q;
  det_t  s1_det_q;
  sqs_t  s2_q, s2_d;
  sqs_t  sq_q [SQ_STAGES];
  sqs_t  sq_src [SQ_STAGES];
  tr_t   t_d;
  disc_t disc;

  val_t  lre_q [2], lim_q [2], xre_q [2], xim_q [2], yre_q [2], yim_q [2];
  val_t  lre_d [2], lim_d [2], xre_d [2], xim_d [2], yre_d [2], yim_d [2];

  // A stage takes new data when it is empty or its content moves on.
  assign ld_out   = !ov_q || (phase_q && out_o.ready);

  always_comb begin
    ld_sq[SQ_STAGES-1] = !sq_v_q[SQ_STAGES-1] || ld_out;
    for (int k = SQ_STAGES - 2; k >= 0; k--) begin
      ld_sq[k] = !sq_v_q[k] || ld_sq[k+1];
    end
  end

  assign ld2      = !s2_v_q || ld_sq[0];
  assign ld1      = !s1_v_q || ld2;
  assign ld0      = !s0_v_q || ld1;
  assign in_i.ready = ld0;

  assign sq_v_src = {sq_v_q[SQ_STAGES-2:0], s2_v_q};
  assign sq_src[0] = s2_q;
  for (genvar k = 1; k < SQ_STAGES; k++) begin : g_src
    assign sq_src[k] = sq_q[k-1];
  end

  assign t_d = T_W'(in_i.a00) + T_W'(in_i.a11);

  always_comb begin
    disc = DISC_W'(s1_tt_q) - (DISC_W'(s1_det_q) <<< 2);
    s2_d.m       = s1_m_q;
    s2_d.t       = s1_t_q;
    s2_d.neg     = disc[DISC_W-1];
    s2_d.sq.rad  = disc[DISC_W-1] ? RAD_W'(-disc) : RAD_W'(disc);
    s2_d.sq.rem  = '0;
    s2_d.sq.root = '0;
  end

  always_comb begin
    sqs_t fin;
    val_t sv;
    val_t tv;
    fin = sq_q[SQ_STAGES-1];
    sv  = val_t'(fin.sq.root);
    tv  = val_t'(fin.t);
    for (int k = 0; k < 2; k++) begin
      if (fin.neg) begin
        lre_d[k] = tv;
        lim_d[k] = (k == 0) ? sv : -sv;
      end else begin
        lre_d[k] = (k == 0) ? tv + sv : tv - sv;
        lim_d[k] = '0;
      end
      if (fin.m.a10 != '0) begin
        xre_d[k] = lre_d[k] - (val_t'(fin.m.a11) <<< 1);
        xim_d[k] = lim_d[k];
        yre_d[k] = val_t'(fin.m.a10) <<< 1;
        yim_d[k] = '0;
      end else if (fin.m.a01 != '0) begin
        xre_d[k] = val_t'(fin.m.a01) <<< 1;
        xim_d[k] = '0;
        yre_d[k] = lre_d[k] - (val_t'(fin.m.a00) <<< 1);
        yim_d[k] = lim_d[k];
      end else begin
        xre_d[k] = (k == 0) ? ONE_V : '0;
        xim_d[k] = '0;
        yre_d[k] = (k == 0) ? '0 : ONE_V;
        yim_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      sq_v_q  <= '0;
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (ld0) s0_v_q <= in_i.valid;
      if (ld1) s1_v_q <= s0_v_q;
      if (ld2) s2_v_q <= s1_v_q;
      for (int k = 0; k < SQ_STAGES; k++) begin
        if (ld_sq[k]) sq_v_q[k] <= sq_v_src[k];
      end
      if (ld_out) begin
        ov_q    <= sq_v_q[SQ_STAGES-1];
        phase_q <= 1'b0;
      end else if (out_o.ready) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      s0_m_q  <= '{a00: in_i.a00, a01: in_i.a01, a10: in_i.a10, a11: in_i.a11};
      s0_t_q  <= t_d;
      s0_p0_q <= PROD_W'(in_i.a00) * PROD_W'(in_i.a11);
      s0_p1_q <= PROD_W'(in_i.a01) * PROD_W'(in_i.a10);
      s0_tt_q <= TT_W'(t_d) * TT_W'(t_d);
    end
    if (ld1) begin
      s1_m_q   <= s0_m_q;
      s1_t_q   <= s0_t_q;
      s1_tt_q  <= s0_tt_q;
      s1_det_q <= DET_W'(s0_p0_q) - DET_W'(s0_p1_q);
    end
    if (ld2) s2_q <= s2_d;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (ld_sq[k]) sq_q[k] <= sqrt_run(sq_src[k]);
    end
    if (ld_out) begin
      lre_q <= lre_d;
      lim_q <= lim_d;
      xre_q <= xre_d;
      xim_q <= xim_d;
      yre_q <= yre_d;
      yim_q <= yim_d;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.last      = phase_q;
  assign out_o.lambda_re = lre_q[phase_q];
  assign out_o.lambda_im = lim_q[phase_q];
  assign out_o.vec_x_re  = xre_q[phase_q];
  assign out_o.vec_x_im  = xim_q[phase_q];
  assign out_o.vec_y_re  = yre_q[phase_q];
  assign out_o.vec_y_im  = yim_q[phase_q];

endmodule

`default_nettype wire

@@ rtl/eig2_checker.sv @@
// Port-level checker for eigen_pairs_2x2 and its bind statement.
`default_nettype none

`include "eigen_pairs_2x2_assert.svh"

module eig2_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  logic           out_last_i,
  input  eig2_pkg::val_t lambda_re_i,
  input  eig2_pkg::val_t lambda_im_i,
  input  eig2_pkg::val_t vec_x_re_i,
  input  eig2_pkg::val_t vec_x_im_i,
  input  eig2_pkg::val_t vec_y_re_i,
  input  eig2_pkg::val_t vec_y_im_i
);
  import eig2_pkg::*;

  logic [6*RES_W:0] beat;
  logic             first_taken;

  assign beat = {out_last_i, lambda_re_i, lambda_im_i, vec_x_re_i, vec_x_im_i,
                 vec_y_re_i, vec_y_im_i};
  assign first_taken = out_valid_i && out_ready_i && !out_last_i;

  // A stalled beat keeps its payload.
  `EIG2_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(beat), "stalled result beat changed")
  // The second eigenpair beat directly follows the first.
  `EIG2_ASSERT_NEXT(a_pair_order, clk_i, rst_ni, first_taken, out_valid_i && out_last_i, "second eigenpair beat missing")
  // The two eigenvalues of one matrix are complex conjugates or both real.
  `EIG2_ASSERT_NEXT(a_conjugate, clk_i, rst_ni, first_taken, lambda_im_i == -$past(lambda_im_i), "eigenvalue imaginary parts do not mirror")
  // The plus-root eigenvalue never has a negative imaginary part.
  `EIG2_ASSERT_SAME(a_im_sign, clk_i, rst_ni, out_valid_i && !out_last_i, !lambda_im_i[RES_W-1], "first eigenvalue has negative imaginary part")

endmodule

bind eigen_pairs_2x2 eig2_checker u_eig2_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last),
  .lambda_re_i (out_o.lambda_re),
  .lambda_im_i (out_o.lambda_im),
  .vec_x_re_i  (out_o.vec_x_re),
  .vec_x_im_i  (out_o.vec_x_im),
  .vec_y_re_i  (out_o.vec_y_re),
  .vec_y_im_i  (out_o.vec_y_im)
);

`default_nettype wire
